[src/tbc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_pkg
// Shared types, sizes and the set hash for the translated block cache.
// ----------------------------------------------------------------------------
package tbc_pkg;

	localparam int NUM_SETS    = 1024;
	localparam int NUM_WAYS    = 4;
	localparam int HANDLE_BITS = 48;

	localparam int SET_BITS  = $clog2(NUM_SETS);
	localparam int WAY_BITS  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int PC_W      = 64;
	localparam int CODE_W    = 48;
	localparam int WAYOUT_W  = 3;
	localparam int CNT_W     = 32;
	localparam int HASH_W    = 32;
	localparam int PC_DROP   = 2;
	localparam int HASH_FOLD = 10;

	localparam logic REQ_LOOKUP = 1'b0;
	localparam logic REQ_INSERT = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [PC_W-1:0]   pc;
		logic [CODE_W-1:0] code_handle;
	} tbc_req_t;

	typedef struct packed {
		logic                hit;
		logic [CODE_W-1:0]   code_out;
		logic [WAYOUT_W-1:0] way_written;
		logic [CNT_W-1:0]    hit_total;
		logic [CNT_W-1:0]    miss_total;
	} tbc_rsp_t;

	typedef struct packed {
		logic [PC_W-1:0]        tag;
		logic [HANDLE_BITS-1:0] handle;
	} entry_t;

	typedef entry_t [NUM_WAYS-1:0] row_t;

	typedef struct packed {
		logic                hit;
		logic [CODE_W-1:0]   code;
		logic [WAY_BITS-1:0] way;
		logic                wr_en;
		row_t                new_row;
	} way_res_t;

	typedef enum logic {
		ST_CLEAR,
		ST_RUN
	} tbc_state_t;

	function automatic logic [SET_BITS-1:0] set_of(input logic [PC_W-1:0] pc);
		logic [HASH_W-1:0] h;
		h = pc[PC_DROP +: HASH_W];
		h = h ^ (h >> HASH_FOLD);
		return h[SET_BITS-1:0];
	endfunction

endpackage

[src/translated_block_cache_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// translated_block_cache_core
// Set-associative cache from guest pc to translated code handle.
//
//   channel | signals                  | beat
//   --------+--------------------------+--------------------------------
//   req     | req_valid, req_stall     | tbc_req_t: type, pc, handle
//   rsp     | rsp_valid, rsp_stall     | tbc_rsp_t: hit, code, way, counts
//
// one beat per cycle when rsp is not stalled; set row read at accept,
// compare in the next cycle, write-back and response register when the
// compare stage advances. back-to-back beats to the same set use the row
// forwarded from the write port.
// after reset a clearing pass zeroes every row of the memory; req
// is stalled until it ends. a stalled rsp holds the compare stage and req.
// ----------------------------------------------------------------------------
module translated_block_cache_core
	import tbc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  tbc_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output tbc_rsp_t rsp
);

	tbc_state_t state_q, state_nxt;
	logic [SET_BITS-1:0] clr_q;
	logic clearing;

	logic accept;
	logic s1_adv;

	logic                valid_s1;
	tbc_req_t            req_s1;
	logic [SET_BITS-1:0] set_s1;
	logic                fwd_s1;
	row_t                fwd_row_s1;

	row_t     ram_rdata;
	row_t     cur_row;
	way_res_t res;

	logic                ram_we;
	logic [SET_BITS-1:0] ram_waddr;
	row_t                ram_wdata;
	logic [SET_BITS-1:0] req_set;

	logic [CNT_W-1:0] hit_cnt_q, miss_cnt_q;
	logic [CNT_W-1:0] hit_cnt_nxt, miss_cnt_nxt;

	logic     rsp_valid_q;
	tbc_rsp_t rsp_q;

	// clear sequencer
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == SET_BITS'(NUM_SETS - 1)) begin
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: state_nxt = ST_RUN;
			default: state_nxt = ST_CLEAR;
		endcase
	end

	always_comb begin
		case (state_q)
			ST_CLEAR: clearing = 1'b1;
			ST_RUN:   clearing = 1'b0;
			default:  clearing = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (clearing) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// handshake
	assign s1_adv    = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = clearing || (valid_s1 && !s1_adv);
	assign accept    = req_valid && !req_stall;
	assign req_set   = set_of(req.pc);

	// memory port
	always_comb begin
		if (clearing) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = s1_adv && res.wr_en;
			ram_waddr = set_s1;
			ram_wdata = res.new_row;
		end
	end

	tbc_row_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (req_set),
		.rdata (ram_rdata)
	);

	assign cur_row = fwd_s1 ? fwd_row_s1 : ram_rdata;

	tbc_way_logic u_way (
		.req (req_s1),
		.row (cur_row),
		.res (res)
	);

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				fwd_s1   <= ram_we && !clearing && (ram_waddr == req_set);
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1     <= req;
			set_s1     <= req_set;
			fwd_row_s1 <= res.new_row;
		end
	end

	// counters and response register
	always_comb begin
		hit_cnt_nxt  = hit_cnt_q;
		miss_cnt_nxt = miss_cnt_q;
		if (req_s1.req_type == REQ_LOOKUP) begin
			if (res.hit) begin
				hit_cnt_nxt = hit_cnt_q + 1'b1;
			end else begin
				miss_cnt_nxt = miss_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (s1_adv) begin
				hit_cnt_q   <= hit_cnt_nxt;
				miss_cnt_q  <= miss_cnt_nxt;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rsp_q.hit         <= res.hit;
			rsp_q.code_out    <= res.code;
			rsp_q.way_written <= WAYOUT_W'(res.way);
			rsp_q.hit_total   <= hit_cnt_nxt;
			rsp_q.miss_total  <= miss_cnt_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !valid_s1 && !rsp_valid_q)
		else $error("pipeline busy during clearing pass");

	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted beat did not reach compare stage");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_adv |=> valid_s1 && $stable(set_s1) && $stable(fwd_s1))
		else $error("stalled compare stage lost its beat");

	a_lookup_counts: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && req_s1.req_type == REQ_LOOKUP
			|=> hit_cnt_q != $past(hit_cnt_q) || miss_cnt_q != $past(miss_cnt_q))
		else $error("lookup did not update a counter");

	a_insert_counts: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && req_s1.req_type == REQ_INSERT
			|=> $stable(hit_cnt_q) && $stable(miss_cnt_q))
		else $error("insert changed a counter");

endmodule

[src/tbc_row_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_row_ram
// One row per set holding all ways; one write port, one registered read port.
// ----------------------------------------------------------------------------
module tbc_row_ram
	import tbc_pkg::*;
(
	input  logic                clk,
	input  logic                we,
	input  logic [SET_BITS-1:0] waddr,
	input  row_t                wdata,
	input  logic                re,
	input  logic [SET_BITS-1:0] raddr,
	output row_t                rdata
);

	row_t mem [NUM_SETS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/tbc_way_logic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_way_logic
// Parallel way compare for lookups and free-way pick for inserts (way 0 when none is free).
// ----------------------------------------------------------------------------
module tbc_way_logic
	import tbc_pkg::*;
(
	input  tbc_req_t req,
	input  row_t     row,
	output way_res_t res
);

	logic [NUM_WAYS-1:0] match;
	logic [NUM_WAYS-1:0] free;
	logic [WAY_BITS-1:0] hit_way;
	logic [WAY_BITS-1:0] pick;
	logic                any_hit;

	always_comb begin
		for (int w = 0; w < NUM_WAYS; w++) begin
			match[w] = (row[w].tag == req.pc) && (row[w].handle != '0);
			free[w]  = (row[w].tag == '0);
		end
	end

	always_comb begin
		hit_way = '0;
		pick    = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				hit_way = WAY_BITS'(w);
			end
			if (free[w]) begin
				pick = WAY_BITS'(w);
			end
		end
		any_hit = |match;
	end

	always_comb begin
		res         = '0;
		res.new_row = row;
		if (req.req_type == REQ_INSERT) begin
			res.wr_en                    = 1'b1;
			res.way                      = pick;
			res.new_row[pick].tag        = req.pc;
			res.new_row[pick].handle     = HANDLE_BITS'(req.code_handle);
		end else begin
			res.hit = any_hit;
			if (any_hit) begin
				res.code = CODE_W'(row[hit_way].handle);
			end
		end
	end

endmodule
